/* design/pulse_energy_meter_unit_macros.svh */
// Assertion macros for the pulse energy meter.
// Included by the modules that check their own sequencing; needs nothing else.
`ifndef PULSE_ENERGY_METER_UNIT_MACROS_SVH
`define PULSE_ENERGY_METER_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define PEM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pem: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define PEM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pem: next-cycle check failed");

`endif

/* design/pem_pkg.sv */
// Shared types and constants of the pulse energy meter.
// No dependencies; used by the interfaces and every module.
package pem_pkg;

    localparam int VAL_W             = 32;
    localparam int PF_W              = 16;
    localparam int DEN_W             = VAL_W + PF_W;
    localparam int FUNC_W            = 2;
    localparam int KIND_W            = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int COUNTER_WIDTH_DEF = 32;

    // 3.6e12 = 3600 s * 1000 W * 1e6 us per kWh
    localparam int WATT_NUM_W = 42;
    localparam logic [WATT_NUM_W-1:0] WATT_NUM = 42'd3600000000000;

    // kWh is reported in units of 0.0001 kWh
    localparam int KWH_SCALE_W = 14;
    localparam logic [KWH_SCALE_W-1:0] KWH_SCALE = 14'd10000;

    localparam int DIV_WIDTH_DEF =
        (COUNTER_WIDTH_DEF + KWH_SCALE_W > WATT_NUM_W) ?
        COUNTER_WIDTH_DEF + KWH_SCALE_W : WATT_NUM_W;

    localparam logic [PF_W-1:0]  PF_RST      = 16'd1000;
    localparam logic [VAL_W-1:0] MAX_W_RST   = 32'd10000;
    localparam logic [VAL_W-1:0] INTV_RST    = 32'd20000;
    localparam logic [VAL_W-1:0] MIN_GAP_RST = 32'd10000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PULSE   = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_RESTORE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [KIND_W-1:0] {
        KIND_WATT  = 2'd0,
        KIND_COUNT = 2'd1,
        KIND_KWH   = 2'd2,
        KIND_REQ   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PF      = 3'd0,
        CFG_SLEEP   = 3'd1,
        CFG_MAX_W   = 3'd2,
        CFG_INTV    = 3'd3,
        CFG_MIN_GAP = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PCHK,
        ST_PDIV,
        ST_TDEC,
        ST_TDIV,
        ST_TEMIT
    } t_state;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
    } t_div_res;

    typedef struct packed {
        t_kind            kind;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_push;

endpackage

/* design/pem_if.sv */
// Request and result channels of the pulse energy meter.
// Depends on pem_pkg for field widths.
interface pem_in_if;
    logic                           valid;
    logic                           ready;
    logic [pem_pkg::FUNC_W-1:0]     func;
    logic [pem_pkg::VAL_W-1:0]      pulse_time_us;
    logic [pem_pkg::VAL_W-1:0]      tick_time_ms;
    logic [pem_pkg::VAL_W-1:0]      restored_count;

    modport source (output valid, func, pulse_time_us, tick_time_ms, restored_count,
                    input ready);
    modport sink (input valid, func, pulse_time_us, tick_time_ms, restored_count,
                  output ready);
endinterface

interface pem_out_if;
    logic                           valid;
    logic                           ready;
    logic [pem_pkg::KIND_W-1:0]     kind;
    logic [pem_pkg::VAL_W-1:0]      value;
    logic                           last;

    modport source (output valid, kind, value, last, input ready);
    modport sink (input valid, kind, value, last, output ready);
endinterface

/* design/pulse_energy_meter_unit.sv */
// Pulse energy meter top level: sequencer, meter state and configuration.
// Depends on pem_pkg, pem_if, pem_divider, pem_out_stage and the macros header.
//
// Requests enter on i_req (valid/ready): func 0 is a meter pulse with a us
// timestamp, func 1 a report tick with a ms time, func 2 restores the count,
// func 3 is dropped. Results leave on o_res (valid/ready) as kind/value/last;
// only ticks produce results, at most three, last marking the final one.
// One request is worked at a time; i_req.ready is high only when idle.
// A pulse in sleep mode or a restore is finished in the idle state; a glitch
// pulse is dropped in the check state. A measured pulse goes on to the divide
// state and the shared bit-serial divider, DIV_W = max(42, COUNTER_WIDTH + 14).
// A tick passes the decide state, then the kWh divide when it reports and the
// count changed, then the emit state, which pushes one result at a time and
// waits while the output register stays full.
// The output register holds a result while the receiver stalls; the meter
// takes the next request as soon as the last result is in that register.
// Synchronous reset restores the default configuration and zeroes the meter state.
// Configuration writes (i_cfg_we) land at once and are meant for idle time.
`include "pulse_energy_meter_unit_macros.svh"

module pulse_energy_meter_unit #(
    parameter int COUNTER_WIDTH = pem_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pem_in_if.sink                          i_req,
    pem_out_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [pem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pem_pkg::VAL_W-1:0]       i_cfg_data
);

    localparam int VW    = pem_pkg::VAL_W;
    localparam int DEN_W = pem_pkg::DEN_W;
    localparam int DIV_W = (COUNTER_WIDTH + pem_pkg::KWH_SCALE_W > pem_pkg::WATT_NUM_W) ?
                           COUNTER_WIDTH + pem_pkg::KWH_SCALE_W : pem_pkg::WATT_NUM_W;

    // configuration
    logic [pem_pkg::PF_W-1:0] r_pf;
    logic                     r_sleep;
    logic [VW-1:0]            r_max_w;
    logic [VW-1:0]            r_intv;
    logic [VW-1:0]            r_min_gap;

    // meter state
    logic [COUNTER_WIDTH-1:0] r_count;
    logic [COUNTER_WIDTH-1:0] r_rcount;
    logic [VW-1:0]            r_last_edge;
    logic [VW-1:0]            r_pw;
    logic [VW-1:0]            r_rw;
    logic [VW-1:0]            r_rkwh;
    logic [VW-1:0]            r_last_rep;
    logic                     r_restored;

    // work registers
    pem_pkg::t_state          r_state;
    pem_pkg::t_state          n_state;
    logic [VW-1:0]            r_time;
    logic [VW-1:0]            r_gap;
    logic [3:0]               r_pend;

    logic                     in_ready;
    logic                     acc;
    pem_pkg::t_func           func;
    logic                     glitch;
    logic [VW-1:0]            since_rep;
    logic                     send;
    logic                     active;
    logic                     cnt_ch;
    logic                     div_start;
    logic [DIV_W-1:0]         div_num;
    logic [DEN_W-1:0]         div_den;
    pem_pkg::t_div_res        div_res;
    logic                     st_ready;
    pem_pkg::t_push           push;
    pem_pkg::t_kind           sel;
    logic [3:0]               rest;
    logic [3:0]               tick_pend;
    logic                     kwh_done;

    assign acc       = i_req.valid && in_ready;
    assign func      = pem_pkg::t_func'(i_req.func);
    assign glitch    = r_gap < r_min_gap;
    assign since_rep = r_time - r_last_rep;
    assign send      = since_rep > r_intv;
    assign active    = r_restored && (r_sleep || send);
    assign cnt_ch    = r_count != r_rcount;
    assign kwh_done  = (r_state == pem_pkg::ST_TDIV) && div_res.done;

    // pick the lowest pending result kind; watt, count, kWh come out in that order
    always_comb begin
        sel = pem_pkg::KIND_REQ;
        for (int i = 3; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel = pem_pkg::t_kind'(i);
            end
        end
        rest      = r_pend;
        rest[sel] = 1'b0;
    end

    // results a tick raises before the kWh divide
    always_comb begin
        tick_pend = '0;
        if (active) begin
            tick_pend[pem_pkg::KIND_WATT]  = !r_sleep && r_pw != r_rw && r_pw < r_max_w;
            tick_pend[pem_pkg::KIND_COUNT] = cnt_ch;
        end else if (send && !r_restored) begin
            tick_pend[pem_pkg::KIND_REQ] = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pem_pkg::ST_IDLE: begin
                if (acc && func == pem_pkg::FUNC_PULSE && !r_sleep) begin
                    n_state = pem_pkg::ST_PCHK;
                end else if (acc && func == pem_pkg::FUNC_TICK) begin
                    n_state = pem_pkg::ST_TDEC;
                end
            end
            pem_pkg::ST_PCHK: begin
                n_state = glitch ? pem_pkg::ST_IDLE : pem_pkg::ST_PDIV;
            end
            pem_pkg::ST_PDIV: begin
                if (div_res.done) begin
                    n_state = pem_pkg::ST_IDLE;
                end
            end
            pem_pkg::ST_TDEC: begin
                n_state = (active && cnt_ch) ? pem_pkg::ST_TDIV : pem_pkg::ST_TEMIT;
            end
            pem_pkg::ST_TDIV: begin
                if (div_res.done) begin
                    n_state = pem_pkg::ST_TEMIT;
                end
            end
            pem_pkg::ST_TEMIT: begin
                if (r_pend == 4'b0000 || (push.valid && rest == 4'b0000)) begin
                    n_state = pem_pkg::ST_IDLE;
                end
            end
            default: n_state = pem_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        div_num   = DIV_W'(pem_pkg::WATT_NUM);
        div_den   = DEN_W'(r_gap) * DEN_W'(r_pf);
        push      = '0;
        case (r_state)
            pem_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            pem_pkg::ST_PCHK: begin
                div_start = !glitch;
            end
            pem_pkg::ST_TDEC: begin
                // round half up: (count * 10000 + pf / 2) / pf
                div_start = active && cnt_ch;
                div_num   = DIV_W'(r_count) * DIV_W'(pem_pkg::KWH_SCALE)
                          + DIV_W'(r_pf >> 1);
                div_den   = DEN_W'(r_pf);
            end
            pem_pkg::ST_TEMIT: begin
                push.valid    = (r_pend != 4'b0000) && st_ready;
                push.res.kind = sel;
                push.res.last = rest == 4'b0000;
                case (sel)
                    pem_pkg::KIND_WATT:  push.res.value = r_pw;
                    pem_pkg::KIND_COUNT: push.res.value = VW'(r_count);
                    pem_pkg::KIND_KWH:   push.res.value = r_rkwh;
                    default:             push.res.value = '0;
                endcase
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_req.ready = in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf      <= pem_pkg::PF_RST;
            r_sleep   <= 1'b0;
            r_max_w   <= pem_pkg::MAX_W_RST;
            r_intv    <= pem_pkg::INTV_RST;
            r_min_gap <= pem_pkg::MIN_GAP_RST;
        end else if (i_cfg_we) begin
            case (pem_pkg::t_cfg_idx'(i_cfg_idx))
                pem_pkg::CFG_PF:      r_pf      <= i_cfg_data[pem_pkg::PF_W-1:0];
                pem_pkg::CFG_SLEEP:   r_sleep   <= i_cfg_data[0];
                pem_pkg::CFG_MAX_W:   r_max_w   <= i_cfg_data;
                pem_pkg::CFG_INTV:    r_intv    <= i_cfg_data;
                pem_pkg::CFG_MIN_GAP: r_min_gap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // meter state and work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pem_pkg::ST_IDLE;
            r_count     <= '0;
            r_rcount    <= '0;
            r_last_edge <= '0;
            r_pw        <= '0;
            r_rw        <= '0;
            r_rkwh      <= '0;
            r_last_rep  <= '0;
            r_restored  <= 1'b0;
            r_pend      <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                pem_pkg::ST_IDLE: begin
                    if (acc) begin
                        case (func)
                            pem_pkg::FUNC_PULSE: begin
                                if (r_sleep) begin
                                    r_count <= r_count + COUNTER_WIDTH'(1);
                                end
                            end
                            pem_pkg::FUNC_RESTORE: begin
                                r_count    <= COUNTER_WIDTH'(i_req.restored_count);
                                r_rcount   <= COUNTER_WIDTH'(i_req.restored_count);
                                r_restored <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                pem_pkg::ST_PDIV: begin
                    if (div_res.done) begin
                        r_pw        <= div_res.quot;
                        r_last_edge <= r_time;
                        r_count     <= r_count + COUNTER_WIDTH'(1);
                    end
                end
                pem_pkg::ST_TDEC: begin
                    r_pend <= tick_pend;
                    if (active) begin
                        if (!r_sleep && r_pw != r_rw) begin
                            r_rw <= r_pw;
                        end
                        if (cnt_ch) begin
                            r_rcount <= r_count;
                        end
                        r_last_rep <= r_time;
                    end else if (send && !r_restored) begin
                        r_last_rep <= r_time;
                    end
                end
                pem_pkg::ST_TDIV: begin
                    if (div_res.done && div_res.quot != r_rkwh) begin
                        r_pend[pem_pkg::KIND_KWH] <= 1'b1;
                        r_rkwh                    <= div_res.quot;
                    end
                end
                pem_pkg::ST_TEMIT: begin
                    if (push.valid) begin
                        r_pend <= rest;
                    end
                end
                default: ;
            endcase
        end
    end

    // request payload captured at accept
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_time <= (func == pem_pkg::FUNC_TICK) ? i_req.tick_time_ms : i_req.pulse_time_us;
            r_gap  <= i_req.pulse_time_us - r_last_edge;
        end
    end

    pem_divider #(
        .DIV_WIDTH (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_res      (div_res)
    );

    pem_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_can_load (st_ready),
        .o_res      (o_res)
    );

    `PEM_ASSERT_NEXT(a_no_push_after_acc, i_clk, i_rst_n, acc, !push.valid)
    `PEM_ASSERT_NEXT(a_restored_holds, i_clk, i_rst_n, r_restored, r_restored)
    `PEM_ASSERT_NEXT(a_kwh_to_emit, i_clk, i_rst_n, kwh_done, r_state == pem_pkg::ST_TEMIT)

endmodule

/* design/pem_divider.sv */
// Shared restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// Depends on pem_pkg and the assertion macros header.
`include "pulse_energy_meter_unit_macros.svh"

module pem_divider #(
    parameter int DIV_WIDTH = pem_pkg::DIV_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DIV_WIDTH-1:0]        i_dividend,
    input  logic [pem_pkg::DEN_W-1:0]   i_divisor,
    output pem_pkg::t_div_res           o_res
);

    localparam int CNT_W = $clog2(DIV_WIDTH + 1);
    localparam int DW    = pem_pkg::DEN_W;
    localparam int VW    = pem_pkg::VAL_W;

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_done;
    logic [DIV_WIDTH-1:0] r_num;
    logic [DW-1:0]        r_div;
    logic [DW-1:0]        r_rem;
    logic [VW-1:0]        r_q;
    logic                 r_ovf;

    logic [DW:0]          trial;
    logic [DW:0]          diff;
    logic                 fits;
    logic [DW-1:0]        n_rem;

    always_comb begin
        trial = {r_rem, r_num[DIV_WIDTH-1]};
        diff  = trial - {1'b0, r_div};
        fits  = trial >= {1'b0, r_div};
        n_rem = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_WIDTH);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_num <= {r_num[DIV_WIDTH-2:0], 1'b0};
            r_q   <= {r_q[VW-2:0], fits};
            // any quotient bit above the low 32 forces saturation
            r_ovf <= r_ovf | r_q[VW-1];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_ovf ? '1 : r_q;

    `PEM_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, r_cnt == '0)
    `PEM_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start, r_cnt != '0)
    `PEM_ASSERT_IMP(a_done_after, i_clk, i_rst_n, r_done, r_cnt == '0)

endmodule

/* design/pem_out_stage.sv */
// Output register between the sequencer and the result channel.
// Depends on pem_pkg and pem_if.
module pem_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pem_pkg::t_push      i_push,
    output logic                o_can_load,
    pem_out_if.source           o_res
);

    logic          r_valid;
    pem_pkg::t_res r_res;

    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_push.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_push.valid) begin
            r_res <= i_push.res;
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.kind  = r_res.kind;
    assign o_res.value = r_res.value;
    assign o_res.last  = r_res.last;

endmodule

/* verif/tb.sv */
// Self-checking testbench for pulse_energy_meter_unit: drives pulse, tick and restore requests
// and checks every watt, count, kWh and count-request result against an internal predictor.
// Depends on pem_pkg and the pem_in_if / pem_out_if interfaces of the design.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VAL_W         = pem_pkg::VAL_W;
    localparam int PF_W          = pem_pkg::PF_W;
    localparam int CFG_IDX_W     = pem_pkg::CFG_IDX_W;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [VAL_W-1:0]     cfg_data;

    pem_in_if  req_ch ();
    pem_out_if res_ch ();

    pulse_energy_meter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predicted meter state and configuration
    logic [PF_W-1:0]  exp_pf;
    bit               exp_sleep;
    logic [VAL_W-1:0] exp_watt_cap;
    logic [VAL_W-1:0] exp_interval;
    logic [VAL_W-1:0] exp_min_gap;
    logic [VAL_W-1:0] exp_count;
    logic [VAL_W-1:0] exp_count_sent;
    logic [VAL_W-1:0] exp_edge_us;
    logic [VAL_W-1:0] exp_watt;
    logic [VAL_W-1:0] exp_watt_sent;
    logic [VAL_W-1:0] exp_kwh_sent;
    logic [VAL_W-1:0] exp_sent_ms;
    bit               exp_restored;

    pem_pkg::t_res pending_reports[$];
    int   mismatches = 0;
    bit   idle_on = 1'b1;
    bit   stall_on = 1'b1;
    int   hold_off_cycles = 0;

    function automatic logic [VAL_W-1:0] watt_for_gap(logic [VAL_W-1:0] gap);
        logic [63:0] den;
        logic [63:0] q;
        den = 64'(gap) * 64'(exp_pf);
        if (den == 64'd0)
            return ALL_ONES;
        q = 64'(pem_pkg::WATT_NUM) / den;
        return (q > 64'(ALL_ONES)) ? ALL_ONES : q[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] kwh_for_count(logic [VAL_W-1:0] cnt);
        logic [63:0] pf;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] v;
        pf = 64'(exp_pf);
        if (pf == 64'd0)
            return ALL_ONES;
        q = 64'(cnt) / pf;
        r = 64'(cnt) % pf;
        // beyond this whole-kWh count the scaled value cannot fit 32 bits
        if (q > 64'd429497)
            return ALL_ONES;
        v = q * 64'(pem_pkg::KWH_SCALE) + (r * 64'(pem_pkg::KWH_SCALE) + pf / 64'd2) / pf;
        return (v > 64'(ALL_ONES)) ? ALL_ONES : v[VAL_W-1:0];
    endfunction

    function automatic pem_pkg::t_res report_of(pem_pkg::t_kind k, logic [VAL_W-1:0] v);
        pem_pkg::t_res r;
        r.kind  = k;
        r.value = v;
        r.last  = 1'b0;
        return r;
    endfunction

    task automatic predict_reports(pem_pkg::t_func f, logic [VAL_W-1:0] pulse_us,
                                   logic [VAL_W-1:0] tick_ms, logic [VAL_W-1:0] count);
        pem_pkg::t_res    found[$];
        logic [VAL_W-1:0] gap;
        logic [VAL_W-1:0] kwh;
        bit               due;
        case (f)
            pem_pkg::FUNC_PULSE: begin
                if (!exp_sleep) begin
                    gap = pulse_us - exp_edge_us;
                    if (gap < exp_min_gap)
                        return;
                    exp_watt    = watt_for_gap(gap);
                    exp_edge_us = pulse_us;
                end
                exp_count = exp_count + 1'b1;
            end
            pem_pkg::FUNC_TICK: begin
                due = (tick_ms - exp_sent_ms) > exp_interval;
                if (exp_restored && (exp_sleep || due)) begin
                    if (!exp_sleep && exp_watt != exp_watt_sent) begin
                        if (exp_watt < exp_watt_cap)
                            found.push_back(report_of(pem_pkg::KIND_WATT, exp_watt));
                        exp_watt_sent = exp_watt;
                    end
                    if (exp_count != exp_count_sent) begin
                        kwh = kwh_for_count(exp_count);
                        found.push_back(report_of(pem_pkg::KIND_COUNT, exp_count));
                        exp_count_sent = exp_count;
                        if (kwh != exp_kwh_sent) begin
                            found.push_back(report_of(pem_pkg::KIND_KWH, kwh));
                            exp_kwh_sent = kwh;
                        end
                    end
                    exp_sent_ms = tick_ms;
                end else if (due && !exp_restored) begin
                    found.push_back(report_of(pem_pkg::KIND_REQ, '0));
                    exp_sent_ms = tick_ms;
                end
            end
            pem_pkg::FUNC_RESTORE: begin
                exp_count      = count;
                exp_count_sent = count;
                exp_restored   = 1'b1;
            end
            default: ;
        endcase
        if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            pending_reports.push_back(found[i]);
    endtask

    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(12, 60);
    endfunction

    task automatic note_mismatch(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic send_req(pem_pkg::t_func f, logic [VAL_W-1:0] pulse_us,
                            logic [VAL_W-1:0] tick_ms, logic [VAL_W-1:0] count);
        int unsigned gap;
        gap = idle_on ? idle_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.func           <= f;
        req_ch.pulse_time_us  <= pulse_us;
        req_ch.tick_time_ms   <= tick_ms;
        req_ch.restored_count <= count;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_reports(f, pulse_us, tick_ms, count);
    endtask

    // Drop valid, wait for every predicted result, then let a pulse divide finish.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            pem_pkg::CFG_PF:      exp_pf       = data[PF_W-1:0];
            pem_pkg::CFG_SLEEP:   exp_sleep    = data[0];
            pem_pkg::CFG_MAX_W:   exp_watt_cap = data;
            pem_pkg::CFG_INTV:    exp_interval = data;
            pem_pkg::CFG_MIN_GAP: exp_min_gap  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [PF_W-1:0] pf, bit sleep, logic [VAL_W-1:0] watt_cap,
                              logic [VAL_W-1:0] interval, logic [VAL_W-1:0] min_gap);
        wait_drained();
        write_reg(pem_pkg::CFG_PF, VAL_W'(pf));
        write_reg(pem_pkg::CFG_SLEEP, VAL_W'(sleep));
        write_reg(pem_pkg::CFG_MAX_W, watt_cap);
        write_reg(pem_pkg::CFG_INTV, interval);
        write_reg(pem_pkg::CFG_MIN_GAP, min_gap);
    endtask

    // Mostly well-formed pulses and due ticks, with glitches, early ticks and noise mixed in.
    task automatic random_items(int count);
        int unsigned      pick;
        int unsigned      shape;
        int               sent;
        logic [VAL_W-1:0] t;
        sent = 0;
        while (sent < count) begin
            pick  = $urandom_range(0, 99);
            shape = $urandom_range(0, 19);
            if (pick < 55) begin
                if (shape < 16)
                    t = exp_edge_us + exp_min_gap + $urandom_range(0, 2000000);
                else if (shape < 19)
                    t = exp_edge_us + $urandom_range(0, exp_min_gap);
                else
                    t = $urandom();
                send_req(pem_pkg::FUNC_PULSE, t, $urandom(), $urandom());
                sent++;
            end else if (pick < 85) begin
                if (shape < 16)
                    t = exp_sent_ms + exp_interval + $urandom_range(1, 1000);
                else if (shape < 19)
                    t = exp_sent_ms + $urandom_range(0, exp_interval);
                else
                    t = $urandom();
                send_req(pem_pkg::FUNC_TICK, $urandom(), t, $urandom());
                sent++;
            end else if (pick < 95) begin
                t = (shape < 14) ? VAL_W'($urandom_range(0, 5000)) : VAL_W'($urandom());
                send_req(pem_pkg::FUNC_RESTORE, $urandom(), $urandom(), t);
                sent++;
            end else begin
                send_req(pem_pkg::FUNC_NONE, $urandom(), $urandom(), $urandom());
            end
        end
    endtask

    // Count requests before any restore, glitch filter and timer wrap at reset settings.
    task automatic test_count_request();
        send_req(pem_pkg::FUNC_TICK, '0, 32'd20001, '0);
        send_req(pem_pkg::FUNC_TICK, '0, 32'd20002, '0);
        send_req(pem_pkg::FUNC_TICK, '0, 32'd0, '0);
        send_req(pem_pkg::FUNC_PULSE, 32'd5000, '0, '0);
        send_req(pem_pkg::FUNC_PULSE, 32'd15000, '0, '0);
        send_req(pem_pkg::FUNC_NONE, $urandom(), $urandom(), $urandom());
        send_req(pem_pkg::FUNC_PULSE, ALL_ONES, '0, '0);
        send_req(pem_pkg::FUNC_PULSE, 32'd9000, '0, '0);
        send_req(pem_pkg::FUNC_PULSE, 32'd20000, '0, '0);
    endtask

    // Watt saturation, zero divisor, kWh rounding and saturation, count wrap.
    task automatic test_power_reports();
        set_config(16'd1000, 1'b0, ALL_ONES, '0, 32'd10000);
        for (int i = pem_pkg::CFG_MIN_GAP + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), $urandom());
        send_req(pem_pkg::FUNC_RESTORE, '0, '0, ALL_ONES);
        send_req(pem_pkg::FUNC_PULSE, exp_edge_us + 32'd1000000, '0, '0);
        send_req(pem_pkg::FUNC_TICK, '0, exp_sent_ms + 1, '0);
        send_req(pem_pkg::FUNC_TICK, '0, exp_sent_ms + 1, '0);

        set_config(16'd1, 1'b0, ALL_ONES, '0, '0);
        send_req(pem_pkg::FUNC_PULSE, exp_edge_us, '0, '0);
        send_req(pem_pkg::FUNC_PULSE, exp_edge_us + 32'd839, '0, '0);
        send_req(pem_pkg::FUNC_TICK, '0, exp_sent_ms + 1, '0);
        send_req(pem_pkg::FUNC_PULSE, exp_edge_us + 32'd1, '0, '0);
        send_req(pem_pkg::FUNC_TICK, '0, exp_sent_ms + 1, '0);
        send_req(pem_pkg::FUNC_RESTORE, '0, '0, 32'd429497);
        send_req(pem_pkg::FUNC_PULSE, exp_edge_us + 32'd1000000, '0, '0);
        send_req(pem_pkg::FUNC_TICK, '0, exp_sent_ms + 1, '0);

        set_config(16'd0, 1'b0, ALL_ONES, '0, '0);
        send_req(pem_pkg::FUNC_PULSE, exp_edge_us + 32'd5, '0, '0);
        send_req(pem_pkg::FUNC_TICK, '0, exp_sent_ms + 1, '0);

        // one pulse at this factor lands exactly on half a unit
        set_config(16'd20000, 1'b0, ALL_ONES, '0, '0);
        send_req(pem_pkg::FUNC_RESTORE, '0, '0, '0);
        send_req(pem_pkg::FUNC_PULSE, exp_edge_us + 32'd7, '0, '0);
        send_req(pem_pkg::FUNC_TICK, '0, exp_sent_ms + 1, '0);
    endtask

    task automatic test_random_phases();
        set_config(16'd1000, 1'b0, 32'd10000, 32'd20000, 32'd10000);
        random_items(40);
        set_config(16'd1, 1'b0, ALL_ONES, '0, '0);
        random_items(35);
        set_config(16'hFFFF, 1'b1, '0, ALL_ONES, ALL_ONES);
        random_items(30);
        set_config(PF_W'($urandom_range(1, 65535)), 1'b0, $urandom_range(1000, 100000),
                   $urandom_range(0, 200), $urandom_range(0, 50000));
        random_items(40);
        // run back to back with no gaps on either side
        set_config(16'd3, 1'b0, ALL_ONES, 32'd5, 32'd1);
        idle_on  = 1'b0;
        stall_on = 1'b0;
        random_items(35);
        idle_on  = 1'b1;
        stall_on = 1'b1;
    endtask

    // Hold the result side off while ticks keep coming, so the meter backs up.
    task automatic test_backpressure();
        set_config(16'd1000, 1'b1, ALL_ONES, '0, '0);
        send_req(pem_pkg::FUNC_RESTORE, '0, '0, $urandom_range(0, 100000));
        hold_off_cycles = LONG_HOLD;
        idle_on = 1'b0;
        repeat (8) begin
            send_req(pem_pkg::FUNC_PULSE, $urandom(), '0, '0);
            send_req(pem_pkg::FUNC_TICK, '0, $urandom(), '0);
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin : result_ready_gen
        int unsigned stall;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                stall = idle_gap();
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        pem_pkg::t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_reports.size() == 0) begin
                note_mismatch("unexpected result value", '0, res_ch.value);
            end else begin
                want = pending_reports.pop_front();
                if (res_ch.kind !== want.kind)
                    note_mismatch("kind", VAL_W'(want.kind), VAL_W'(res_ch.kind));
                if (res_ch.value !== want.value)
                    note_mismatch("value", want.value, res_ch.value);
                if (res_ch.last !== want.last)
                    note_mismatch("last", VAL_W'(want.last), VAL_W'(res_ch.last));
            end
        end
    end

    initial begin : run_limit
        #(2_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        exp_pf         = pem_pkg::PF_RST;
        exp_sleep      = 1'b0;
        exp_watt_cap   = pem_pkg::MAX_W_RST;
        exp_interval   = pem_pkg::INTV_RST;
        exp_min_gap    = pem_pkg::MIN_GAP_RST;
        exp_count      = '0;
        exp_count_sent = '0;
        exp_edge_us    = '0;
        exp_watt       = '0;
        exp_watt_sent  = '0;
        exp_kwh_sent   = '0;
        exp_sent_ms    = '0;
        exp_restored   = 1'b0;

        i_rst_n               <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_idx               <= pem_pkg::CFG_PF;
        cfg_data              <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.func           <= pem_pkg::FUNC_NONE;
        req_ch.pulse_time_us  <= '0;
        req_ch.tick_time_ms   <= '0;
        req_ch.restored_count <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_count_request();
        test_power_reports();
        test_random_phases();
        test_backpressure();
        wait_drained();

        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/pem_pkg.sv
design/pem_if.sv
design/pem_divider.sv
design/pem_out_stage.sv
design/pulse_energy_meter_unit.sv
verif/tb.sv
